@@ rtl/core/ygb_pkg.sv @@
// ----------------------------------------------------------------------------
// ygb_pkg
// shared types and constants of the gray bar YUV420P pattern source
// ----------------------------------------------------------------------------
package ygb_pkg;

	// field and register widths
	localparam int CFG_DIM_W   = 13;
	localparam int LUMA_W      = 8;
	localparam int PLANE_W     = 2;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_W   = 3;

	// default dimensions and levels
	localparam int DEF_MAX_DIM = 4096;
	localparam int DEF_WIDTH   = 640;
	localparam int DEF_HEIGHT  = 480;
	localparam int DEF_BARS    = 10;
	localparam int DEF_DIM_W   = 10;
	localparam logic [LUMA_W-1:0] CHROMA_LEVEL  = 8'd128;
	localparam logic [LUMA_W-1:0] RST_LUMA_LOW  = 8'd16;
	localparam logic [LUMA_W-1:0] RST_LUMA_HIGH = 8'd235;

	// plane codes
	localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
	localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
	localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BAR_COUNT    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LUMA_LOW     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LUMA_HIGH    = 3'd4;

	// which quotient the shared divider is working on
	typedef enum logic [1:0] {
		DIV_BAR_WIDTH,
		DIV_BAR_INDEX,
		DIV_RAMP
	} div_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     start;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul_en;
		logic     emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ramp;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/core/ygb_div.sv @@
// ----------------------------------------------------------------------------
// ygb_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ygb_div #(
	parameter int NW = 21,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;

	logic [DW:0]   shifted;
	logic [DW+1:0] trial;
	logic          borrow;

	// trial subtraction of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[NW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
	assign borrow  = trial[DW+1];

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ~borrow};
			rem_q <= borrow ? shifted[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/core/ygb_dp.sv @@
// ----------------------------------------------------------------------------
// ygb_dp
// datapath: frame position, bar arithmetic and output register
// ----------------------------------------------------------------------------
module ygb_dp
	import ygb_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           stat,
	input  logic                 restart,
	input  logic [CFG_DIM_W-1:0] frame_width,
	input  logic [CFG_DIM_W-1:0] frame_height,
	input  logic [CFG_DIM_W-1:0] bar_count,
	input  logic [LUMA_W-1:0]    luma_low,
	input  logic [LUMA_W-1:0]    luma_high,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,
	output logic [2:0]           m_axis_tuser,
	output logic                 m_axis_tlast
);

	localparam int DW_RAW = $clog2(MAX_DIM + 1);
	localparam int DW     = (DW_RAW > DEF_DIM_W) ? DW_RAW : DEF_DIM_W;
	localparam int NW     = DW + LUMA_W;
	localparam int CMP_W  = CFG_DIM_W + 1;

	// clamped and defaulted dimensions
	logic          w_big, h_big, b_big, use_def;
	logic [DW-1:0] w_c, h_c, b_c, w, h, b, cw, ch, pw, ph;
	logic          chroma_empty;

	assign w_big = {1'b0, frame_width}  > CMP_W'(MAX_DIM);
	assign h_big = {1'b0, frame_height} > CMP_W'(MAX_DIM);
	assign b_big = {1'b0, bar_count}    > CMP_W'(MAX_DIM);
	assign w_c   = w_big ? DW'(MAX_DIM) : DW'(frame_width);
	assign h_c   = h_big ? DW'(MAX_DIM) : DW'(frame_height);
	assign b_c   = b_big ? DW'(MAX_DIM) : DW'(bar_count);
	assign use_def = (frame_width == '0) || (frame_height == '0) || (bar_count == '0);
	assign w  = use_def ? DW'(DEF_WIDTH)  : w_c;
	assign h  = use_def ? DW'(DEF_HEIGHT) : h_c;
	assign b  = use_def ? DW'(DEF_BARS)   : b_c;
	assign cw = w >> 1;
	assign ch = h >> 1;
	assign chroma_empty = (cw == '0) || (ch == '0);

	// frame position
	logic [DW-1:0]      col_q, row_q;
	logic [PLANE_W-1:0] plane_q;
	logic               rewind;

	// bar arithmetic
	logic [DW-1:0]     bw_q, bar_q;
	logic [NW-1:0]     prod_q;
	logic              neg_q;
	logic [LUMA_W-1:0] ramp_q;
	logic [LUMA_W-1:0] abs_diff;
	logic              neg_diff;

	// output register
	logic              ovalid_q;
	logic [LUMA_W-1:0] osample_q;
	logic [PLANE_W-1:0] oplane_q;
	logic              oline_q, oframe_q;

	// divider hookup
	logic          div_done;
	logic [NW-1:0] div_quo, div_dvd;
	logic [DW-1:0] div_dsr;

	ygb_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	// operand select for the shared divider
	always_comb begin
		case (cmd.div_sel)
			DIV_BAR_WIDTH: begin
				div_dvd = NW'(w);
				div_dsr = b;
			end
			DIV_BAR_INDEX: begin
				div_dvd = NW'(col_q);
				div_dsr = bw_q;
			end
			DIV_RAMP: begin
				div_dvd = prod_q;
				div_dsr = b - 1'b1;
			end
			default: begin
				div_dvd = '0;
				div_dsr = '1;
			end
		endcase
	end

	// signed luma span as sign and magnitude
	assign neg_diff = luma_high < luma_low;
	assign abs_diff = neg_diff ? (luma_low - luma_high) : (luma_high - luma_low);

	// bar width, bar index, product and ramp offset
	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_sel)
				DIV_BAR_WIDTH: bw_q <= (div_quo == '0) ? DW'(1) : div_quo[DW-1:0];
				DIV_BAR_INDEX: bar_q <= div_quo[DW-1:0];
				DIV_RAMP: ramp_q <= neg_q ? (LUMA_W'(0) - div_quo[LUMA_W-1:0])
					: div_quo[LUMA_W-1:0];
				default: ;
			endcase
		end
		if (cmd.mul_en) begin
			prod_q <= NW'(bar_q) * NW'(abs_diff);
			neg_q  <= neg_diff;
		end
	end

	// current plane geometry and end flags
	logic               line_end, last_row, frame_end;
	logic [LUMA_W-1:0]  sample;

	assign pw = (plane_q == PLANE_Y) ? w : cw;
	assign ph = (plane_q == PLANE_Y) ? h : ch;
	assign line_end  = ({1'b0, col_q} + 1'b1) >= {1'b0, pw};
	assign last_row  = ({1'b0, row_q} + 1'b1) >= {1'b0, ph};
	assign frame_end = line_end && last_row &&
		((plane_q == PLANE_V) || ((plane_q == PLANE_Y) && chroma_empty));
	assign rewind = restart || (plane_q > PLANE_V) || ((plane_q != PLANE_Y) && chroma_empty);

	always_comb begin
		if (plane_q != PLANE_Y) begin
			sample = CHROMA_LEVEL;
		end else if (b == DW'(1)) begin
			sample = luma_low;
		end else begin
			sample = luma_low + ramp_q;
		end
	end

	// position update: rewind on accept on restart or a stale plane, advance on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= PLANE_Y;
		end else if (cmd.start) begin
			if (rewind) begin
				col_q   <= '0;
				row_q   <= '0;
				plane_q <= PLANE_Y;
			end
		end else if (cmd.emit) begin
			if (!line_end) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q <= row_q + 1'b1;
				end else begin
					row_q   <= '0;
					plane_q <= frame_end ? PLANE_Y : plane_q + 1'b1;
				end
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			osample_q <= sample;
			oplane_q  <= plane_q;
			oline_q   <= line_end;
			oframe_q  <= frame_end;
		end
	end

	assign stat.ramp     = (plane_q == PLANE_Y) && (b != DW'(1));
	assign stat.div_done = div_done;
	assign stat.out_free = !ovalid_q || m_axis_tready;

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = osample_q;
	assign m_axis_tuser  = {oline_q, oplane_q};
	assign m_axis_tlast  = oframe_q;

endmodule

@@ rtl/core/ygb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ygb_ctrl
// sequencer: takes one beat at a time; a ramp beat steps through the bar width, bar index, product and ramp
// ----------------------------------------------------------------------------
module ygb_ctrl
	import ygb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  dp_status_t stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV_BW,
		ST_DIV_T,
		ST_MUL,
		ST_DIV_Q,
		ST_EMIT
	} state_t;

	state_t   state_q;
	logic     rdy_q;
	logic     div_start_q;
	div_sel_t div_sel_q;
	logic     mul_q;

	// state and registered commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rdy_q       <= 1'b1;
			div_start_q <= 1'b0;
			div_sel_q   <= DIV_BAR_WIDTH;
			mul_q       <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			mul_q       <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && rdy_q) begin
						rdy_q   <= 1'b0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (stat.ramp) begin
						div_start_q <= 1'b1;
						div_sel_q   <= DIV_BAR_WIDTH;
						state_q     <= ST_DIV_BW;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIV_BW: begin
					if (stat.div_done) begin
						div_start_q <= 1'b1;
						div_sel_q   <= DIV_BAR_INDEX;
						state_q     <= ST_DIV_T;
					end
				end
				ST_DIV_T: begin
					if (stat.div_done) begin
						mul_q   <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					div_start_q <= 1'b1;
					div_sel_q   <= DIV_RAMP;
					state_q     <= ST_DIV_Q;
				end
				ST_DIV_Q: begin
					if (stat.div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (stat.out_free) begin
						rdy_q   <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					rdy_q   <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = rdy_q;

	assign cmd.start     = s_axis_tvalid && rdy_q;
	assign cmd.div_start = div_start_q;
	assign cmd.div_sel   = div_sel_q;
	assign cmd.mul_en    = mul_q;
	assign cmd.emit      = (state_q == ST_EMIT) && stat.out_free;

endmodule

@@ rtl/core/yuv420p_gray_bar_pattern.sv @@
// ----------------------------------------------------------------------------
// yuv420p_gray_bar_pattern
// gray bar test pattern source, planar YUV420P, one byte per output beat
// ----------------------------------------------------------------------------
// Each input beat asks for the next byte of the frame: luma in raster order,
// then the U and V planes (width/2 by height/2, all 128). A luma byte on the
// ramp takes three passes of one shared radix-2 divider (bar width, bar
// index, ramp offset) and one multiply; its dividend is NW = DW+8 bits wide
// and DW = max(clog2(MAX_DIM+1), 10). Chroma bytes and luma with a single
// bar skip the divider. A finished beat waits in the output register while
// the next input beat is taken. Registers sit at byte addresses 0x00 width,
// 0x04 height, 0x08 bar count, 0x0c low luma, 0x10 high luma; change them
// only while the block is idle.
// ----------------------------------------------------------------------------
module yuv420p_gray_bar_pattern
	import ygb_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// request stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [0] restart
	// pixel stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // [7:0] sample
	output logic [2:0]            m_axis_tuser,  // [1:0] plane, [2] line_end
	output logic                  m_axis_tlast   // frame_end
);

	logic [CFG_DIM_W-1:0] frame_width_q, frame_height_q, bar_count_q;
	logic [LUMA_W-1:0]    luma_low_q, luma_high_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_DIM_W'(DEF_WIDTH);
			frame_height_q <= CFG_DIM_W'(DEF_HEIGHT);
			bar_count_q    <= CFG_DIM_W'(DEF_BARS);
			luma_low_q     <= RST_LUMA_LOW;
			luma_high_q    <= RST_LUMA_HIGH;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_DIM_W-1:0];
				REG_BAR_COUNT:    bar_count_q    <= pwdata[CFG_DIM_W-1:0];
				REG_LUMA_LOW:     luma_low_q     <= pwdata[LUMA_W-1:0];
				REG_LUMA_HIGH:    luma_high_q    <= pwdata[LUMA_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			REG_BAR_COUNT:    prdata = APB_DATA_W'(bar_count_q);
			REG_LUMA_LOW:     prdata = APB_DATA_W'(luma_low_q);
			REG_LUMA_HIGH:    prdata = APB_DATA_W'(luma_high_q);
			default:          prdata = '0;
		endcase
	end

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	ygb_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	ygb_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.restart       (s_axis_tdata[0]),
		.frame_width   (frame_width_q),
		.frame_height  (frame_height_q),
		.bar_count     (bar_count_q),
		.luma_low      (luma_low_q),
		.luma_high     (luma_high_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ rtl/core/ygb_checker.sv @@
// ----------------------------------------------------------------------------
// ygb_checker
// port level checks of the gray bar pattern source
// ----------------------------------------------------------------------------
module ygb_checker
	import ygb_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// a stalled beat holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled pixel beat changed");

	// the frame's last byte also ends its line
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2])
		else $error("frame end without line end");

	// plane code stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
		else $error("bad plane code");

	// chroma bytes are mid level
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] != PLANE_Y) |-> m_axis_tdata == CHROMA_LEVEL)
		else $error("chroma byte not mid level");

endmodule

bind yuv420p_gray_bar_pattern ygb_checker u_ygb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

@@ test/yuv420p_gray_bar_pattern_tb.sv @@
// ----------------------------------------------------------------------------
// yuv420p_gray_bar_pattern_tb
// self-checking bench for the gray bar YUV420P pattern source
// ----------------------------------------------------------------------------
// Requests are pushed into the block and every pixel beat that comes back is
// checked against a predictor that walks the same frame position in
// software. A short directed part hits the corner settings: default and
// zero dimensions, oversize registers, a single bar, more bars than pixels,
// empty chroma, a falling ramp that wraps below zero and positions left
// stale by a register change. Random settings follow, mostly with small
// frames so frame ends and both chroma planes come up often. Output stalls
// and, in most random passes, input idles come in bursts, except at the end.
// ----------------------------------------------------------------------------
module yuv420p_gray_bar_pattern_tb
	import ygb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// one pixel beat as seen on the output stream
	typedef struct packed {
		logic [LUMA_W-1:0]  sample;
		logic [PLANE_W-1:0] plane;
		logic               line_end;
		logic               frame_end;
	} pixel_t;

	// frame position tracker and pixel checker
	class pattern_scoreboard;
		bit [CFG_DIM_W-1:0] frame_width, frame_height, bar_count;
		bit [LUMA_W-1:0]    luma_low, luma_high;
		int unsigned        column, row;
		logic [PLANE_W-1:0] plane;
		pixel_t             pending[$];
		int                 errors, checked, frame_ends, restarts, settings;

		function new();
			frame_width  = DEF_WIDTH;
			frame_height = DEF_HEIGHT;
			bar_count    = DEF_BARS;
			luma_low     = RST_LUMA_LOW;
			luma_high    = RST_LUMA_HIGH;
			column       = 0;
			row          = 0;
			plane        = PLANE_Y;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, int unsigned value);
			case (idx)
				REG_FRAME_WIDTH:  frame_width  = value[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height = value[CFG_DIM_W-1:0];
				REG_BAR_COUNT:    bar_count    = value[CFG_DIM_W-1:0];
				REG_LUMA_LOW:     luma_low     = value[LUMA_W-1:0];
				REG_LUMA_HIGH:    luma_high    = value[LUMA_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned limit_size(bit [CFG_DIM_W-1:0] v);
			return (v > DEF_MAX_DIM) ? DEF_MAX_DIM : v;
		endfunction

		// work out the byte for one request and step the frame position
		function void note_request(bit restart);
			int unsigned w, h, b, bw, pw, ph;
			bit          no_chroma, lend, lrow, fend;
			longint      ramp;
			pixel_t      px;
			w = limit_size(frame_width);
			h = limit_size(frame_height);
			b = limit_size(bar_count);
			if (w == 0 || h == 0 || b == 0) begin
				w = DEF_WIDTH;
				h = DEF_HEIGHT;
				b = DEF_BARS;
			end
			bw = w / b;
			if (bw == 0)
				bw = 1;
			no_chroma = (w / 2 == 0) || (h / 2 == 0);
			if (restart)
				restarts++;
			if (restart || plane > PLANE_V || (plane != PLANE_Y && no_chroma)) begin
				column = 0;
				row    = 0;
				plane  = PLANE_Y;
			end
			if (plane == PLANE_Y) begin
				pw = w;
				ph = h;
				if (b == 1) begin
					px.sample = luma_low;
				end else begin
					// signed step, truncated toward zero, wraps mod 256
					ramp = longint'(column / bw) * (longint'(luma_high) - longint'(luma_low))
						/ longint'(b - 1);
					px.sample = 8'(longint'(luma_low) + ramp);
				end
			end else begin
				pw = w / 2;
				ph = h / 2;
				px.sample = CHROMA_LEVEL;
			end
			lend = (column + 1 >= pw);
			lrow = (row + 1 >= ph);
			fend = lend && lrow && (plane == PLANE_V || (plane == PLANE_Y && no_chroma));
			px.plane     = plane;
			px.line_end  = lend;
			px.frame_end = fend;
			pending.push_back(px);
			// advance through line, plane and frame
			if (!lend) begin
				column = (column + 1) & 'h1fff;
			end else begin
				column = 0;
				if (!lrow) begin
					row = (row + 1) & 'h1fff;
				end else begin
					row   = 0;
					plane = fend ? PLANE_Y : plane + 2'd1;
				end
			end
		endfunction

		function string describe(pixel_t px);
			return $sformatf("sample %0d plane %0d line_end %0b frame_end %0b",
				px.sample, px.plane, px.line_end, px.frame_end);
		endfunction

		function void flag(string what, pixel_t want, pixel_t got);
			errors++;
			if (errors <= 10)
				$display("beat %0d: %s differs, expected %s, got %s",
					checked, what, describe(want), describe(got));
		endfunction

		// compare one output beat with the oldest prediction
		function void check_pixel(pixel_t got);
			pixel_t want;
			checked++;
			if (got.frame_end === 1'b1)
				frame_ends++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("beat %0d: nothing expected, got %s", checked, describe(got));
				return;
			end
			want = pending.pop_front();
			if (got.sample !== want.sample)
				flag("sample", want, got);
			if (got.plane !== want.plane)
				flag("plane", want, got);
			if (got.line_end !== want.line_end)
				flag("line_end", want, got);
			if (got.frame_end !== want.frame_end)
				flag("frame_end", want, got);
		endfunction
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [APB_ADDR_W-1:0] paddr         = '0;
	logic [APB_DATA_W-1:0] pwdata        = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;  // [0] restart
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;        // [7:0] sample
	logic [2:0]            m_axis_tuser;        // [1:0] plane, [2] line_end
	logic                  m_axis_tlast;        // frame_end

	bit                calm = 1'b0;
	pattern_scoreboard sb;

	yuv420p_gray_bar_pattern dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// output side: ready runs and stall bursts
	initial forever begin
		bit stall;
		int n;
		stall = !calm && ($urandom_range(0, 3) == 0);
		n     = stall ? $urandom_range(1, 18) : $urandom_range(1, 30);
		repeat (n) begin
			@(posedge clk);
			m_axis_tready <= !stall;
		end
	end

	// pixel beat monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_pixel('{sample: m_axis_tdata, plane: m_axis_tuser[1:0],
				line_end: m_axis_tuser[2], frame_end: m_axis_tlast});
	end

	// register write, setup then access
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int unsigned w, int unsigned h, int unsigned b,
			int unsigned lo, int unsigned hi);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_BAR_COUNT, b);
		write_reg(REG_LUMA_LOW, lo);
		write_reg(REG_LUMA_HIGH, hi);
		sb.settings++;
	endtask

	// one request beat, then maybe an idle burst
	task automatic send_request(bit restart, bit gaps);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, restart};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(restart);
		if (gaps && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// stop sending and let every predicted beat come back
	task automatic end_phase();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, with a restart on the last request
		send_request(1'b0, 1'b0);
		send_request(1'b0, 1'b0);
		send_request(1'b1, 1'b0);
		end_phase();
		// one column, single bar, no chroma planes
		apply_setting(1, 3, 1, 255, 0);
		repeat (4) send_request(1'b0, 1'b0);
		end_phase();
		// oversize width and bar count, both clamped to as many bars as pixels
		apply_setting(5000, 2, 8191, 0, 255);
		repeat (2) send_request(1'b0, 1'b0);
		end_phase();
		// zero width falls back to the default frame
		apply_setting(0, 7, 3, 16, 235);
		repeat (2) send_request(1'b0, 1'b0);
		end_phase();
		// falling ramp running past the last full bar wraps below zero
		apply_setting(8, 4, 3, 200, 10);
		send_request(1'b1, 1'b0);
		repeat (6) send_request(1'b0, 1'b0);
		end_phase();
		// narrower line leaves the column beyond its end
		apply_setting(3, 4, 3, 200, 10);
		repeat (2) send_request(1'b0, 1'b0);
		end_phase();
		// walk into the chroma planes, then drop them with a one-column frame
		apply_setting(2, 2, 2, 0, 255);
		send_request(1'b1, 1'b0);
		repeat (4) send_request(1'b0, 1'b0);
		end_phase();
		apply_setting(1, 2, 2, 0, 255);
		repeat (2) send_request(1'b0, 1'b0);
		end_phase();

		// random settings, mostly small frames
		for (int p = 0; p < 12; p++) begin
			int unsigned w, h, b;
			bit          gaps;
			if (p == 11)
				calm = 1'b1;
			case (p)
				0: apply_setting(4096, 4096, 4096, 0, 255);
				1: apply_setting(2, 2, 2, 255, 0);
				default: begin
					w = $urandom_range(1, 24);
					h = $urandom_range(1, 12);
					b = $urandom_range(0, w + 3);
					if ($urandom_range(0, 5) == 0)
						w = $urandom_range(25, 8191);
					apply_setting(w, h, b, $urandom_range(0, 255), $urandom_range(0, 255));
				end
			endcase
			gaps = !calm && ($urandom_range(0, 3) != 0);
			for (int i = 0; i < 100; i++) begin
				send_request($urandom_range(0, 39) == 0, gaps);
				// hold off once until the block has drained
				if (p == 3 && i == 50)
					end_phase();
			end
			end_phase();
		end

		repeat (100) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.errors += sb.pending.size();
			$display("%0d predicted beats never came out", sb.pending.size());
		end
		$display("checked %0d pixel beats over %0d register settings", sb.checked, sb.settings);
		$display("saw %0d frame ends and %0d restarts, %0d mismatches",
			sb.frame_ends, sb.restarts, sb.errors);
		if (sb.errors == 0)
			$display("yuv420p_gray_bar_pattern_tb: clean");
		else
			$display("yuv420p_gray_bar_pattern_tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout, stream stopped moving");
		$display("yuv420p_gray_bar_pattern_tb: errors");
		$finish;
	end

endmodule

@@ yuv420p_gray_bar_pattern.f @@
rtl/core/ygb_pkg.sv
rtl/core/ygb_div.sv
rtl/core/ygb_dp.sv
rtl/core/ygb_ctrl.sv
rtl/core/yuv420p_gray_bar_pattern.sv
rtl/core/ygb_checker.sv
test/yuv420p_gray_bar_pattern_tb.sv
